[rtl/core/agaf_pkg.sv]
// ----------------------------------------------------------------------------
// agaf_pkg: shared types and constants for the affine gap alignment fill
// field widths, register indexes, reset values and the cell control struct
// ----------------------------------------------------------------------------
package agaf_pkg;

	// field and port widths
	localparam int LEN_W       = 11;
	localparam int PEN_W       = 16;
	localparam int SUB_W       = 8;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int OUT_SCORE_W = 32;
	localparam int TRACE_W     = 3;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 144;

	// default parameter values
	localparam int DEF_MAX_LEN = 1024;
	localparam int DEF_SCORE_W = 32;

	// minus infinity and the width it needs as a signed value
	localparam int NEG_INF   = -1000000;
	localparam int NEG_INF_W = 21;

	// border cost: extend penalty times (run length - 1), plus open penalty
	localparam int PROD_W     = PEN_W + LEN_W;
	localparam int PROD_SUM_W = PROD_W + 1;

	// saturation level of the gap run lengths
	localparam logic [LEN_W-1:0] LEN_SAT = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAP_OPEN        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_EXTEND      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MODE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHARGE_OVERHANG = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE     = 3'd5;

	// register reset values
	localparam logic [PEN_W-1:0] RST_GAP_OPEN   = 16'd10;
	localparam logic [PEN_W-1:0] RST_GAP_EXTEND = 16'd1;
	localparam logic [LEN_W-1:0] RST_SIZE       = 11'd1024;

	// per-cell control handed to the cell datapath
	typedef struct packed {
		logic local_mode;
		logic first_col;
		logic first_row;
	} cell_ctrl_t;

endpackage

[rtl/core/agaf_ram.sv]
// ----------------------------------------------------------------------------
// agaf_ram: generic single-clock ram
// one write port, one read port with registered read data (old data on a
// same-address read and write)
// ----------------------------------------------------------------------------
module agaf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/agaf_cell.sv]
// ----------------------------------------------------------------------------
// agaf_cell: one gotoh cell
// border selection, gap and match recurrences with saturation, local clamp,
// gap run lengths and traceback bits
// ----------------------------------------------------------------------------
module agaf_cell #(
	parameter int SCORE_WIDTH = agaf_pkg::DEF_SCORE_W
) (
	input  agaf_pkg::cell_ctrl_t                   ctrl,
	input  logic signed [agaf_pkg::SUB_W-1:0]      sub_score,
	input  logic [agaf_pkg::PEN_W-1:0]             gap_open,
	input  logic [agaf_pkg::PEN_W-1:0]             gap_extend,
	input  logic signed [SCORE_WIDTH-1:0]          up_m,
	input  logic signed [SCORE_WIDTH-1:0]          up_ix,
	input  logic signed [SCORE_WIDTH-1:0]          up_iy,
	input  logic [agaf_pkg::LEN_W-1:0]             up_vgap,
	input  logic signed [SCORE_WIDTH-1:0]          diag_m,
	input  logic signed [SCORE_WIDTH-1:0]          diag_ix,
	input  logic signed [SCORE_WIDTH-1:0]          diag_iy,
	input  logic signed [SCORE_WIDTH-1:0]          left_m,
	input  logic signed [SCORE_WIDTH-1:0]          left_ix,
	input  logic [agaf_pkg::LEN_W-1:0]             left_hgap,
	input  logic signed [SCORE_WIDTH-1:0]          border_col,
	input  logic signed [SCORE_WIDTH-1:0]          border_row,
	input  logic signed [SCORE_WIDTH-1:0]          border_prev,
	output logic signed [SCORE_WIDTH-1:0]          sel_up_m,
	output logic signed [SCORE_WIDTH-1:0]          sel_up_ix,
	output logic signed [SCORE_WIDTH-1:0]          sel_up_iy,
	output logic signed [SCORE_WIDTH-1:0]          m_score,
	output logic signed [SCORE_WIDTH-1:0]          ix_score,
	output logic signed [SCORE_WIDTH-1:0]          iy_score,
	output logic signed [SCORE_WIDTH-1:0]          v_score,
	output logic [agaf_pkg::LEN_W-1:0]             hgap_len,
	output logic [agaf_pkg::LEN_W-1:0]             vgap_len,
	output logic [agaf_pkg::TRACE_W-1:0]           trace_bits
);

	import agaf_pkg::*;

	localparam int XW = SCORE_WIDTH + 2;
	localparam logic signed [XW-1:0] SAT_HI = {3'b000, {(SCORE_WIDTH-1){1'b1}}};
	localparam logic signed [XW-1:0] SAT_LO = {3'b111, {(SCORE_WIDTH-1){1'b0}}};
	localparam logic signed [SCORE_WIDTH-1:0] MINUS_INF =
		(SCORE_WIDTH >= NEG_INF_W) ? SCORE_WIDTH'(NEG_INF) : SAT_LO[SCORE_WIDTH-1:0];

	function automatic logic signed [SCORE_WIDTH-1:0] sat(input logic signed [XW-1:0] x);
		logic signed [SCORE_WIDTH-1:0] r;
		if (x > SAT_HI) begin
			r = SAT_HI[SCORE_WIDTH-1:0];
		end else if (x < SAT_LO) begin
			r = SAT_LO[SCORE_WIDTH-1:0];
		end else begin
			r = x[SCORE_WIDTH-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [SCORE_WIDTH-1:0] max2(
		input logic signed [SCORE_WIDTH-1:0] a,
		input logic signed [SCORE_WIDTH-1:0] b
	);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] v);
		return (v == LEN_SAT) ? v : LEN_W'(v + LEN_W'(1));
	endfunction

	logic signed [SCORE_WIDTH-1:0] um, uix, uiy, dm, dix, diy, lm, lix;
	logic [LEN_W-1:0]              uvg, lhg;
	logic signed [XW-1:0]          go_x, ge_x;
	logic signed [SCORE_WIDTH-1:0] ixm, ixx, iym, iyy, ix_raw, iy_raw, dmax, m_raw;
	logic                          clamp;

	// neighbor selection, borders on row 0 and column 0
	always_comb begin
		if (ctrl.first_row) begin
			um  = border_col;
			uix = border_col;
			uiy = MINUS_INF;
			uvg = '0;
		end else begin
			um  = up_m;
			uix = up_ix;
			uiy = up_iy;
			uvg = up_vgap;
		end
		if (ctrl.first_col) begin
			if (ctrl.first_row) begin
				dm  = '0;
				dix = '0;
				diy = '0;
			end else begin
				dm  = border_prev;
				dix = MINUS_INF;
				diy = border_prev;
			end
			lm  = border_row;
			lix = MINUS_INF;
			lhg = '0;
		end else begin
			dm  = diag_m;
			dix = diag_ix;
			diy = diag_iy;
			lm  = left_m;
			lix = left_ix;
			lhg = left_hgap;
		end
	end

	assign sel_up_m  = um;
	assign sel_up_ix = uix;
	assign sel_up_iy = uiy;

	// gap open and extend candidates
	assign go_x   = XW'({1'b0, gap_open});
	assign ge_x   = XW'({1'b0, gap_extend});
	assign ixm    = sat(XW'(lm) - go_x);
	assign ixx    = sat(XW'(lix) - ge_x);
	assign iym    = sat(XW'(um) - go_x);
	assign iyy    = sat(XW'(uiy) - ge_x);
	assign ix_raw = max2(ixm, ixx);
	assign iy_raw = max2(iym, iyy);

	// match state from the best diagonal state
	assign dmax  = max2(dm, max2(dix, diy));
	assign m_raw = sat(XW'(dmax) + XW'(sub_score));

	// local clamp when no state is above zero
	assign clamp = ctrl.local_mode && (m_raw <= 0) && (ix_raw <= 0) && (iy_raw <= 0);

	assign m_score  = clamp ? '0 : m_raw;
	assign ix_score = clamp ? '0 : ix_raw;
	assign iy_score = clamp ? '0 : iy_raw;
	assign v_score  = max2(m_score, max2(ix_score, iy_score));

	// gap run lengths
	always_comb begin
		if (clamp) begin
			hgap_len = '0;
			vgap_len = '0;
		end else begin
			hgap_len = (ixm >= ixx) ? LEN_W'(1) : len_inc(lhg);
			vgap_len = (iym >= iyy) ? LEN_W'(1) : len_inc(uvg);
		end
	end

	// traceback: which states reach the cell value
	assign trace_bits = clamp ? '0 :
		{(iy_score == v_score), (ix_score == v_score), (m_score == v_score)};

endmodule

[rtl/core/affine_gap_alignment_fill.sv]
// ----------------------------------------------------------------------------
// affine_gap_alignment_fill: gotoh affine gap matrix fill, one cell per word
// a cell passes through the input register (stage 1) and then the result register
// before tvalid rises; an output stall holds the cell in the input register;
// throughput: one cell per cycle while the output is not stalled, set by the row
// buffer ram whose read is issued on accept and whose write is done as the cell
// leaves the input register. reset clears control state and counters to cell (1,1);
// the row buffer needs no clearing.
// ----------------------------------------------------------------------------
module affine_gap_alignment_fill #(
	parameter int MAX_LEN     = agaf_pkg::DEF_MAX_LEN,
	parameter int SCORE_WIDTH = agaf_pkg::DEF_SCORE_W
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [agaf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [agaf_pkg::CFG_W-1:0]          cfg_wdata,
	// input cells
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [agaf_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [7:0] sub_score
	// output cells
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [31:0] m_score, [63:32] ix_score, [95:64] iy_score, [106:96] hgap_len,
	// [117:107] vgap_len, [120:118] trace_bits, [131:121] end_col,
	// [142:132] end_row, [143] zero
	output logic [agaf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast   // end_valid
);

	import agaf_pkg::*;

	localparam int ADDR_W = $clog2(MAX_LEN);
	localparam int WORD_W = 3 * SCORE_WIDTH + LEN_W;
	localparam int NW     = ((SCORE_WIDTH > PROD_SUM_W) ? SCORE_WIDTH : PROD_SUM_W) + 1;
	localparam logic [NW-1:0] SAT_MAG = NW'(1) << (SCORE_WIDTH - 1);
	localparam logic signed [SCORE_WIDTH-1:0] SCORE_MIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};

	// configuration registers
	logic [PEN_W-1:0] gap_open_q, gap_extend_q;
	logic             local_q, charge_q;
	logic [LEN_W-1:0] cols_cfg_q, rows_cfg_q;

	// input side counters
	logic [LEN_W-1:0] col_q, row_q, cols_c, rows_c;

	// stage 1
	logic                          valid_s1;
	logic signed [SUB_W-1:0]       sub_s1;
	logic [LEN_W-1:0]              col_s1, row_s1, cols_s1, rows_s1;
	logic signed [SCORE_WIDTH-1:0] bcol_s1, brow_s1, bprev_s1;
	logic                          byp_s1;
	logic [WORD_W-1:0]             byp_word_s1;

	// cell neighbor state
	logic signed [SCORE_WIDTH-1:0] left_m_q, left_ix_q, diag_m_q, diag_ix_q, diag_iy_q;
	logic [LEN_W-1:0]              left_hgap_q;

	// endpoint tracking
	logic signed [SCORE_WIDTH-1:0] best_value_q, best_row_value_q;
	logic [LEN_W-1:0]              best_col_q, best_row_q;

	// output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic in_accept, go_s1;
	logic [WORD_W-1:0] ram_rdata, up_word, wr_word;
	logic signed [SCORE_WIDTH-1:0] bcol_d, brow_d, bprev_d;

	cell_ctrl_t ctrl;
	logic signed [SCORE_WIDTH-1:0] up_m_sel, up_ix_sel, up_iy_sel;
	logic signed [SCORE_WIDTH-1:0] m_c, ix_c, iy_c, v_c;
	logic [LEN_W-1:0]              hg_c, vg_c;
	logic [TRACE_W-1:0]            tb_c;

	logic                          first_cell, last_cell;
	logic signed [SCORE_WIDTH-1:0] bv0, brv0, bv_n, brv_n;
	logic [LEN_W-1:0]              bc0, br0, bc_n, br_n, end_col, end_row;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		if (v == '0) begin
			r = LEN_W'(1);
		end else if (v > MAX_LEN) begin
			r = LEN_W'(MAX_LEN);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// border score for run length k: -(open + extend * (k - 1)), saturated
	function automatic logic signed [SCORE_WIDTH-1:0] border(input logic [LEN_W-1:0] k);
		logic [PROD_W-1:0]             prod;
		logic [PROD_SUM_W-1:0]         cost;
		logic [NW-1:0]                 neg;
		logic signed [SCORE_WIDTH-1:0] r;
		prod = gap_extend_q * LEN_W'(k - LEN_W'(1));
		cost = PROD_SUM_W'(prod) + PROD_SUM_W'(gap_open_q);
		neg  = NW'(0) - NW'(cost);
		if ((k == '0) || local_q || !charge_q) begin
			r = '0;
		end else if (NW'(cost) > SAT_MAG) begin
			r = SCORE_MIN;
		end else begin
			r = neg[SCORE_WIDTH-1:0];
		end
		return r;
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_open_q   <= RST_GAP_OPEN;
			gap_extend_q <= RST_GAP_EXTEND;
			local_q      <= 1'b0;
			charge_q     <= 1'b0;
			cols_cfg_q   <= RST_SIZE;
			rows_cfg_q   <= RST_SIZE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAP_OPEN:        gap_open_q   <= cfg_wdata[PEN_W-1:0];
				REG_GAP_EXTEND:      gap_extend_q <= cfg_wdata[PEN_W-1:0];
				REG_LOCAL_MODE:      local_q      <= cfg_wdata[0];
				REG_CHARGE_OVERHANG: charge_q     <= cfg_wdata[0];
				REG_COLS_IN_USE:     cols_cfg_q   <= cfg_wdata[LEN_W-1:0];
				REG_ROWS_IN_USE:     rows_cfg_q   <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cols_c = clamp_len(cols_cfg_q);
	assign rows_c = clamp_len(rows_cfg_q);

	// handshake
	assign go_s1         = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || go_s1;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// row-major cell counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= LEN_W'(1);
			row_q <= LEN_W'(1);
		end else if (in_accept) begin
			if (col_q >= cols_c) begin
				col_q <= LEN_W'(1);
				row_q <= (row_q >= rows_c) ? LEN_W'(1) : LEN_W'(row_q + LEN_W'(1));
			end else begin
				col_q <= LEN_W'(col_q + LEN_W'(1));
			end
		end
	end

	// border scores for the accepted cell
	always_comb begin
		bcol_d  = border(col_q);
		brow_d  = border(row_q);
		bprev_d = border(LEN_W'(row_q - LEN_W'(1)));
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload, with forwarding of a same-column row write
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sub_s1      <= s_axis_tdata[SUB_W-1:0];
			col_s1      <= col_q;
			row_s1      <= row_q;
			cols_s1     <= cols_c;
			rows_s1     <= rows_c;
			bcol_s1     <= bcol_d;
			brow_s1     <= brow_d;
			bprev_s1    <= bprev_d;
			byp_s1      <= go_s1 && (col_s1 == col_q);
			byp_word_s1 <= wr_word;
		end
	end

	// row buffer of m, ix, iy and vertical gap length
	agaf_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_LEN)
	) u_row_ram (
		.clk   (clk),
		.we    (go_s1),
		.waddr (ADDR_W'(col_s1 - LEN_W'(1))),
		.wdata (wr_word),
		.re    (in_accept),
		.raddr (ADDR_W'(col_q - LEN_W'(1))),
		.rdata (ram_rdata)
	);

	assign up_word = byp_s1 ? byp_word_s1 : ram_rdata;
	assign wr_word = {vg_c, iy_c, ix_c, m_c};

	// cell datapath
	assign ctrl.local_mode = local_q;
	assign ctrl.first_col  = (col_s1 <= LEN_W'(1));
	assign ctrl.first_row  = (row_s1 <= LEN_W'(1));

	agaf_cell #(
		.SCORE_WIDTH (SCORE_WIDTH)
	) u_cell (
		.ctrl        (ctrl),
		.sub_score   (sub_s1),
		.gap_open    (gap_open_q),
		.gap_extend  (gap_extend_q),
		.up_m        (up_word[SCORE_WIDTH-1:0]),
		.up_ix       (up_word[2*SCORE_WIDTH-1:SCORE_WIDTH]),
		.up_iy       (up_word[3*SCORE_WIDTH-1:2*SCORE_WIDTH]),
		.up_vgap     (up_word[WORD_W-1:3*SCORE_WIDTH]),
		.diag_m      (diag_m_q),
		.diag_ix     (diag_ix_q),
		.diag_iy     (diag_iy_q),
		.left_m      (left_m_q),
		.left_ix     (left_ix_q),
		.left_hgap   (left_hgap_q),
		.border_col  (bcol_s1),
		.border_row  (brow_s1),
		.border_prev (bprev_s1),
		.sel_up_m    (up_m_sel),
		.sel_up_ix   (up_ix_sel),
		.sel_up_iy   (up_iy_sel),
		.m_score     (m_c),
		.ix_score    (ix_c),
		.iy_score    (iy_c),
		.v_score     (v_c),
		.hgap_len    (hg_c),
		.vgap_len    (vg_c),
		.trace_bits  (tb_c)
	);

	// left and diagonal neighbors for the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_m_q    <= '0;
			left_ix_q   <= '0;
			left_hgap_q <= '0;
			diag_m_q    <= '0;
			diag_ix_q   <= '0;
			diag_iy_q   <= '0;
		end else if (go_s1) begin
			left_m_q    <= m_c;
			left_ix_q   <= ix_c;
			left_hgap_q <= hg_c;
			diag_m_q    <= up_m_sel;
			diag_ix_q   <= up_ix_sel;
			diag_iy_q   <= up_iy_sel;
		end
	end

	// endpoint tracking, restarted on the first cell of a matrix
	always_comb begin
		first_cell = (col_s1 == LEN_W'(1)) && (row_s1 == LEN_W'(1));
		last_cell  = (col_s1 >= cols_s1) && (row_s1 >= rows_s1);
		bv0  = first_cell ? '0 : best_value_q;
		brv0 = first_cell ? '0 : best_row_value_q;
		bc0  = first_cell ? cols_s1 : best_col_q;
		br0  = first_cell ? rows_s1 : best_row_q;
		bv_n  = bv0;
		brv_n = brv0;
		bc_n  = bc0;
		br_n  = br0;
		if (local_q) begin
			if (v_c > bv0) begin
				bv_n = v_c;
				bc_n = col_s1;
				br_n = row_s1;
			end
		end else if (!charge_q) begin
			if ((col_s1 == cols_s1) && (v_c > brv0)) begin
				brv_n = v_c;
				br_n  = row_s1;
			end
			if ((row_s1 == rows_s1) && (v_c > bv0)) begin
				bv_n = v_c;
				bc_n = col_s1;
			end
		end
		if (!last_cell) begin
			end_col = '0;
			end_row = '0;
		end else if (local_q) begin
			end_col = bc_n;
			end_row = br_n;
		end else if (charge_q) begin
			end_col = cols_s1;
			end_row = rows_s1;
		end else if (bv_n > brv_n) begin
			end_col = bc_n;
			end_row = rows_s1;
		end else begin
			end_col = cols_s1;
			end_row = br_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_value_q     <= '0;
			best_row_value_q <= '0;
			best_col_q       <= RST_SIZE;
			best_row_q       <= RST_SIZE;
		end else if (go_s1) begin
			best_value_q     <= bv_n;
			best_row_value_q <= brv_n;
			best_col_q       <= bc_n;
			best_row_q       <= br_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			out_data_q <= {end_row, end_col, last_cell, tb_c, vg_c, hg_c,
				OUT_SCORE_W'(iy_c), OUT_SCORE_W'(ix_c), OUT_SCORE_W'(m_c)};
		end
	end

	// output word: the end flag sits between trace bits and end column in the register
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_data_q[3*OUT_SCORE_W + 2*LEN_W + TRACE_W];
	assign m_axis_tdata  = {1'b0,
		out_data_q[OUT_DATA_W-1:3*OUT_SCORE_W + 2*LEN_W + TRACE_W + 1],
		out_data_q[3*OUT_SCORE_W + 2*LEN_W + TRACE_W - 1:0]};

endmodule
